// File: sv/rps_pkg.sv
// ----------------------------------------------------------------------------
// rps_pkg
// shared types, constants and helpers of the permutation shuffler
// ----------------------------------------------------------------------------
package rps_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int RAND_BITS    = 31;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int VAL_W        = IDX_W + 1;
    localparam int PROD_W       = VAL_W + RAND_BITS;

    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 24;

    localparam int OUT_DEPTH    = 4;
    localparam int OUT_PTR_W    = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W    = $clog2(OUT_DEPTH + 1);

    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    // register index, taken from paddr[2]
    localparam logic [0:0] REG_PERM_SIZE = 1'b0;

    localparam logic [VAL_W-1:0] PERM_SIZE_RESET = VAL_W'(MAX_ELEMENTS);

    typedef struct packed {
        logic             touched;
        logic [VAL_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic             last;
        logic [IDX_W-1:0] position;
        logic [VAL_W-1:0] perm_value;
    } result_t;

    // length zero acts as one, anything above the store depth as the depth
    function automatic logic [VAL_W-1:0] eff_size(input logic [VAL_W-1:0] size);
        logic [VAL_W-1:0] res;
        res = size;
        if (size == '0) begin
            res = VAL_W'(1);
        end else if (size > VAL_W'(MAX_ELEMENTS)) begin
            res = VAL_W'(MAX_ELEMENTS);
        end
        return res;
    endfunction

endpackage

// File: sv/rps_ram.sv
// ----------------------------------------------------------------------------
// rps_ram
// synchronous ram, one write port and two read ports, registered read data
// ----------------------------------------------------------------------------
module rps_ram #(
    parameter  int DEPTH  = 1024,
    parameter  int WIDTH  = 12,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr0,
    output logic [WIDTH-1:0]  rdata0,
    input  logic [ADDR_W-1:0] raddr1,
    output logic [WIDTH-1:0]  rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

// File: sv/rps_apb.sv
// ----------------------------------------------------------------------------
// rps_apb
// configuration register file behind an apb-style port
// ----------------------------------------------------------------------------
module rps_apb (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rps_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [rps_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [rps_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready,
    output logic [rps_pkg::VAL_W-1:0]           perm_size
);
    import rps_pkg::*;

    logic [VAL_W-1:0] perm_size_reg;
    logic             hit;

    assign pready = 1'b1;
    assign hit    = (paddr[2:2] == REG_PERM_SIZE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            perm_size_reg <= PERM_SIZE_RESET;
        end else if (psel && penable && pwrite && pready && hit) begin
            perm_size_reg <= pwdata[VAL_W-1:0];
        end
    end

    assign prdata    = hit ? APB_DATA_W'(perm_size_reg) : '0;
    assign perm_size = perm_size_reg;

endmodule

// File: sv/rps_out_fifo.sv
// ----------------------------------------------------------------------------
// rps_out_fifo
// small result queue that decouples the pipeline from the output channel
// ----------------------------------------------------------------------------
module rps_out_fifo (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                push,
    input  rps_pkg::result_t                    push_data,
    output logic [rps_pkg::OUT_CNT_W-1:0]       count,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rps_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                m_tlast
);
    import rps_pkg::*;

    result_t              buf_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg;
    logic [OUT_PTR_W-1:0] rd_ptr_reg;
    logic [OUT_CNT_W-1:0] count_reg;
    logic                 pop;
    result_t              head;

    assign pop  = m_tvalid && m_tready;
    assign head = buf_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + OUT_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + OUT_PTR_W'(1);
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + OUT_CNT_W'(1);
                2'b01:   count_reg <= count_reg - OUT_CNT_W'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign count    = count_reg;
    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = OUT_TDATA_W'({head.position, head.perm_value});
    assign m_tlast  = head.last;

endmodule

// File: sv/random_permutation_shuffler.sv
// ----------------------------------------------------------------------------
// random_permutation_shuffler
// forward fisher-yates shuffle of 1..N, one position per input item
// ----------------------------------------------------------------------------
// Each input item carries one random word r. At position i the block picks
// j = i + ((N - i) * r >> 31), returns the value now at j as the final value
// of position i and moves the value at i into j. Positions run 0..N-1 and
// tlast marks N-1; the next item starts a new permutation. The working
// array lives in a 1024 x 12 ram (value plus a touched mark); an untouched
// entry reads as its index plus one. No new item is taken while the last
// one is still in stage 1, because each item needs two writes to the ram
// (the swap target and the clearing of its own position for the next
// permutation) through its single write port. A result passes stages 1
// and 2 and is then pushed into a four-entry output queue that lets input
// flow on while results wait. After reset, whenever a new length leaves
// the position counter at or beyond it, and at the start of the next
// permutation after a length change in the middle of one, the block runs
// a clearing sweep over all 1024 ram entries during which it accepts no
// item (configuration writes still work).
// N is perm_size, with 0 taken as 1 and values above 1024 taken as 1024.
// ----------------------------------------------------------------------------
module random_permutation_shuffler (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input channel, s_tdata: rand_word[30:0]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [rps_pkg::IN_TDATA_W-1:0]      s_tdata,
    // result channel, m_tdata: perm_value[10:0], position[20:11]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rps_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic                                m_tlast,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [rps_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [rps_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [rps_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import rps_pkg::*;

    typedef enum logic {ST_SWEEP, ST_RUN} state_t;

    // configuration
    logic [VAL_W-1:0]     perm_size;
    logic [VAL_W-1:0]     n_eff;
    logic                 cfg_wr;

    // control
    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     sweep_cnt_reg;
    logic [IDX_W-1:0]     step_reg, step_next;
    logic                 stale_reg;
    logic                 need_clear;
    logic                 pipe_empty;
    logic                 s_acc;
    logic                 acc_last;
    logic [VAL_W-1:0]     acc_diff;
    logic [PROD_W-1:0]    acc_prod;

    // stage 1: pick j, read both entries
    logic                 p1_valid_reg;
    logic [IDX_W-1:0]     p1_i_reg;
    logic [VAL_W-1:0]     p1_n_reg;
    logic                 p1_last_reg;
    logic [PROD_W-1:0]    p1_prod_reg;
    logic [VAL_W:0]       j_sum;
    logic [VAL_W-1:0]     j_val;
    logic [IDX_W-1:0]     j_idx;

    // stage 2: resolve values, write the swap target, emit result
    logic                 p2_valid_reg;
    logic [IDX_W-1:0]     p2_i_reg;
    logic [IDX_W-1:0]     p2_j_reg;
    logic                 p2_last_reg;
    logic                 p2_fwd_i_reg;
    logic                 p2_fwd_j_reg;
    entry_t               p2_fwd_data_reg;
    entry_t               ent_i, ent_j;
    logic [VAL_W-1:0]     vi, vj;

    // stage 3: clear the touched mark of position i
    logic                 p3_valid_reg;
    logic [IDX_W-1:0]     p3_i_reg;

    // ram ports
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    entry_t               ram_wdata;
    logic [$bits(entry_t)-1:0] ram_rdata0, ram_rdata1;

    // output queue
    result_t              push_data;
    logic [OUT_CNT_W-1:0] out_count;

    rps_apb u_apb (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .perm_size (perm_size)
    );

    assign n_eff  = eff_size(perm_size);
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2:2] == REG_PERM_SIZE);

    // a shortened length can strand the position counter past the end;
    // touched marks of that run are then left behind and need a sweep.
    // a length change in the middle of a run can leave marks past the new
    // end, so the next permutation starts with a sweep as well
    assign need_clear = ({1'b0, step_reg} >= n_eff) || (stale_reg && (step_reg == '0));
    assign pipe_empty = !p1_valid_reg && !p2_valid_reg && !p3_valid_reg;

    // no new item while stage 1 holds one, and only with room in the output queue
    // for everything already in flight
    assign s_tready = (state_reg == ST_RUN) && !need_clear && !p1_valid_reg &&
                      ((out_count + OUT_CNT_W'(p2_valid_reg)) < OUT_CNT_W'(OUT_DEPTH));
    assign s_acc    = s_tvalid && s_tready;

    // scaled pick: (N - i) * r, the shift comes in stage 1
    assign acc_last = ({1'b0, step_reg} == (n_eff - VAL_W'(1)));
    assign acc_diff = n_eff - {1'b0, step_reg};
    assign acc_prod = PROD_W'(acc_diff) * PROD_W'(s_tdata[RAND_BITS-1:0]);

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_SWEEP: begin
                if (sweep_cnt_reg == IDX_W'(MAX_ELEMENTS - 1)) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (need_clear && pipe_empty) begin
                    state_next = ST_SWEEP;
                    step_next  = '0;
                end else if (s_acc) begin
                    step_next = acc_last ? '0 : step_reg + IDX_W'(1);
                end
            end
            default: state_next = ST_SWEEP;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_SWEEP;
            sweep_cnt_reg <= '0;
            step_reg      <= '0;
            stale_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (state_reg == ST_SWEEP) begin
                sweep_cnt_reg <= sweep_cnt_reg + IDX_W'(1);
            end else begin
                sweep_cnt_reg <= '0;
            end
            if (cfg_wr && (step_reg != '0)) begin
                stale_reg <= 1'b1;
            end else if (state_reg == ST_SWEEP) begin
                stale_reg <= 1'b0;
            end
        end
    end

    // pipeline valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= s_acc;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    // stage 1 payload
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            p1_i_reg    <= step_reg;
            p1_n_reg    <= n_eff;
            p1_last_reg <= acc_last;
            p1_prod_reg <= acc_prod;
        end
    end

    assign j_sum = (VAL_W + 1)'(p1_i_reg) + (VAL_W + 1)'(p1_prod_reg[PROD_W-1:RAND_BITS]);
    assign j_val = (j_sum >= (VAL_W + 1)'(p1_n_reg)) ? (p1_n_reg - VAL_W'(1))
                                                      : j_sum[VAL_W-1:0];
    assign j_idx = j_val[IDX_W-1:0];

    // stage 2 payload; a write in the same cycle as the reads is forwarded
    always_ff @(posedge aclk) begin
        if (p1_valid_reg) begin
            p2_i_reg        <= p1_i_reg;
            p2_j_reg        <= j_idx;
            p2_last_reg     <= p1_last_reg;
            p2_fwd_i_reg    <= ram_we && (ram_waddr == p1_i_reg);
            p2_fwd_j_reg    <= ram_we && (ram_waddr == j_idx);
            p2_fwd_data_reg <= ram_wdata;
        end
    end

    assign ent_i = p2_fwd_i_reg ? p2_fwd_data_reg : entry_t'(ram_rdata0);
    assign ent_j = p2_fwd_j_reg ? p2_fwd_data_reg : entry_t'(ram_rdata1);
    assign vi    = ent_i.touched ? ent_i.value : (VAL_W'(p2_i_reg) + VAL_W'(1));
    assign vj    = ent_j.touched ? ent_j.value : (VAL_W'(p2_j_reg) + VAL_W'(1));

    // stage 3 payload
    always_ff @(posedge aclk) begin
        if (p2_valid_reg) begin
            p3_i_reg <= p2_i_reg;
        end
    end

    // single write port: sweep, swap target, or clearing of position i;
    // positions below i are never read again, so clearing them readies
    // the array for the next permutation
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = p2_j_reg;
        ram_wdata = '{touched: 1'b0, value: '0};
        if (state_reg == ST_SWEEP) begin
            ram_we    = 1'b1;
            ram_waddr = sweep_cnt_reg;
        end else if (p2_valid_reg) begin
            ram_we    = 1'b1;
            ram_waddr = p2_j_reg;
            ram_wdata = '{touched: 1'b1, value: vi};
        end else if (p3_valid_reg) begin
            ram_we    = 1'b1;
            ram_waddr = p3_i_reg;
        end
    end

    rps_ram #(
        .DEPTH (MAX_ELEMENTS),
        .WIDTH ($bits(entry_t))
    ) u_ram (
        .aclk   (aclk),
        .we     (ram_we),
        .waddr  (ram_waddr),
        .wdata  (ram_wdata),
        .raddr0 (p1_i_reg),
        .rdata0 (ram_rdata0),
        .raddr1 (j_idx),
        .rdata1 (ram_rdata1)
    );

    assign push_data = '{last: p2_last_reg, position: p2_i_reg, perm_value: vj};

    rps_out_fifo u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (p2_valid_reg),
        .push_data (push_data),
        .count     (out_count),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // the swap write and the clearing write never compete for the port
    a_write_port_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !(p2_valid_reg && p3_valid_reg))
        else $error("swap and clear writes collide");

    // the picked target stays inside the permutation
    a_target_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg |-> (j_sum < (VAL_W + 1)'(p1_n_reg)))
        else $error("target index out of range");

    // a result is never pushed into a full queue
    a_queue_room: assert property (@(posedge aclk) disable iff (!aresetn)
        p2_valid_reg |-> (out_count < OUT_CNT_W'(OUT_DEPTH)))
        else $error("output queue overflow");

    // the sweep owns the ram alone
    a_sweep_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP) |-> pipe_empty)
        else $error("item in flight during sweep");

    // after an item the position counter advances or wraps to zero
    a_step_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc |=> (step_reg == '0) || (step_reg == $past(step_reg) + IDX_W'(1)))
        else $error("position counter skipped");

endmodule
